### rtl/dnsmp_pkg.sv
// ----------------------------------------------------------------------------
// DNS message parser package
// Shared widths, section, field and status codes for the byte tagger.
// ----------------------------------------------------------------------------
package dnsmp_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 72;

    localparam logic [2:0] SEC_HEADER     = 3'd0;
    localparam logic [2:0] SEC_QUESTION   = 3'd1;
    localparam logic [2:0] SEC_ADDITIONAL = 3'd4;
    localparam logic [2:0] SEC_BEYOND     = 3'd5;

    localparam logic [3:0] FLD_COUNT_LAST = 4'd5;
    localparam logic [3:0] FLD_LABEL_LEN  = 4'd6;
    localparam logic [3:0] FLD_NAME_CHAR  = 4'd7;
    localparam logic [3:0] FLD_NAME_END   = 4'd8;
    localparam logic [3:0] FLD_TYPE       = 4'd9;
    localparam logic [3:0] FLD_CLASS      = 4'd10;
    localparam logic [3:0] FLD_TTL        = 4'd11;
    localparam logic [3:0] FLD_RDLENGTH   = 4'd12;
    localparam logic [3:0] FLD_RDATA      = 4'd13;
    localparam logic [3:0] FLD_EXTRA      = 4'd14;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_EXTRA     = 2'd2;

    localparam logic [3:0] HDR_LAST_POS = 4'd11;

    typedef enum logic [1:0] {
        PH_LABEL_LEN = 2'd0,
        PH_LABEL_CHR = 2'd1,
        PH_FIXED     = 2'd2,
        PH_RDATA     = 2'd3
    } phase_t;

endpackage

### rtl/dns_message_stream_parser.sv
// ----------------------------------------------------------------------------
// DNS message stream parser
// Tags each message byte with section, field, record number and status.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_      | in  | one message byte, tlast on the final byte
//  m_      | out | one tag item per accepted byte
//
//  One item per cycle while m_tready is high; each byte passes through one
//  state update and one output register.
//  Synchronous active-low reset returns the parser to the header section.
//  s_tready follows m_tready while a result is held; no bytes are dropped.
module dns_message_stream_parser (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dnsmp_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] msg_byte
    input  logic                           s_tlast,  // last_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] section, [6:3] field_code, [14:7] byte_value, [46:15] field_value,
    // [47] field_done, [63:48] record_index, [65:64] status, [66] message_done
    output logic [dnsmp_pkg::M_TDATA_W-1:0] m_tdata
);
    import dnsmp_pkg::*;

    typedef struct packed {
        logic        done;
        logic [2:0]  sec;
        logic [15:0] count;
    } enter_t;

    function automatic enter_t enter_next(input logic [2:0] from,
                                          input logic [3:0][15:0] cnt);
        enter_t r;
        r.done  = 1'b1;
        r.sec   = SEC_BEYOND;
        r.count = '0;
        for (int k = 3; k >= 0; k--) begin
            if (3'(k) >= from && cnt[k] != 16'd0) begin
                r.done  = 1'b0;
                r.sec   = 3'(k + 1);
                r.count = cnt[k];
            end
        end
        return r;
    endfunction

    logic [2:0]       sec_reg, sec_next;
    phase_t           phase_reg, phase_next;
    logic [3:0]       pos_reg, pos_next;
    logic [7:0]       label_reg, label_next;
    logic [31:0]      acc_reg, acc_next;
    logic [15:0]      left_reg, left_next;
    logic [15:0]      recnum_reg, recnum_next;
    logic [3:0][15:0] counts_reg, counts_next;
    logic [15:0]      rdata_reg, rdata_next;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic        accept;
    logic [2:0]  o_sec;
    logic [3:0]  o_code;
    logic [31:0] o_val;
    logic        o_done;
    logic [15:0] o_idx;
    logic [1:0]  o_status;
    logic        o_mdone;

    logic [3:0]  hpos;
    logic [31:0] acc_shift;
    logic        complete;
    logic        rec_end;
    logic [15:0] left_dec;
    logic [15:0] rdata_dec;
    logic [7:0]  label_dec;
    enter_t      ent;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign acc_shift = {acc_reg[23:0], s_tdata};
    assign hpos      = (pos_reg > HDR_LAST_POS) ? HDR_LAST_POS : pos_reg;
    assign left_dec  = left_reg - 16'd1;
    assign rdata_dec = rdata_reg - 16'd1;
    assign label_dec = label_reg - 8'd1;

    always_comb begin
        sec_next    = sec_reg;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        label_next  = label_reg;
        acc_next    = acc_reg;
        left_next   = left_reg;
        recnum_next = recnum_reg;
        counts_next = counts_reg;
        rdata_next  = rdata_reg;
        o_sec    = sec_reg;
        o_code   = 4'd0;
        o_val    = 32'd0;
        o_done   = 1'b0;
        o_idx    = recnum_reg;
        o_status = ST_OK;
        o_mdone  = 1'b0;
        complete = 1'b0;
        rec_end  = 1'b0;
        ent      = enter_next(3'd0, counts_reg);

        if (sec_reg == SEC_HEADER) begin
            o_idx    = 16'd0;
            o_code   = {1'b0, hpos[3:1]};
            acc_next = acc_shift;
            if (hpos[0]) begin
                o_done   = 1'b1;
                o_val    = {16'd0, acc_shift[15:0]};
                acc_next = 32'd0;
                if (hpos >= 4'd4) begin
                    counts_next[2'(hpos[3:1] - 3'd2)] = acc_shift[15:0];
                end
            end
            if (hpos == HDR_LAST_POS) begin
                ent         = enter_next(3'd0, counts_next);
                o_mdone     = ent.done;
                sec_next    = ent.sec;
                left_next   = ent.count;
                recnum_next = 16'd0;
                phase_next  = PH_LABEL_LEN;
                pos_next    = 4'd0;
            end else begin
                pos_next = hpos + 4'd1;
            end
        end else if (sec_reg <= SEC_ADDITIONAL) begin
            case (phase_reg)
                PH_LABEL_LEN: begin
                    o_done = 1'b1;
                    if (s_tdata == 8'd0) begin
                        o_code     = FLD_NAME_END;
                        phase_next = PH_FIXED;
                        pos_next   = 4'd0;
                        acc_next   = 32'd0;
                    end else begin
                        o_code     = FLD_LABEL_LEN;
                        o_val      = {24'd0, s_tdata};
                        label_next = s_tdata;
                        phase_next = PH_LABEL_CHR;
                    end
                end
                PH_LABEL_CHR: begin
                    o_code     = FLD_NAME_CHAR;
                    o_done     = 1'b1;
                    o_val      = {24'd0, s_tdata};
                    label_next = label_dec;
                    if (label_dec == 8'd0) begin
                        phase_next = PH_LABEL_LEN;
                    end
                end
                PH_FIXED: begin
                    acc_next = acc_shift;
                    if (sec_reg == SEC_QUESTION) begin
                        o_code   = (pos_reg < 4'd2) ? FLD_TYPE : FLD_CLASS;
                        complete = (pos_reg == 4'd1) || (pos_reg >= 4'd3);
                    end else begin
                        o_code   = (pos_reg < 4'd2) ? FLD_TYPE :
                                   (pos_reg < 4'd4) ? FLD_CLASS :
                                   (pos_reg < 4'd8) ? FLD_TTL : FLD_RDLENGTH;
                        complete = (pos_reg == 4'd1) || (pos_reg == 4'd3) ||
                                   (pos_reg == 4'd7) || (pos_reg >= 4'd9);
                    end
                    if (complete) begin
                        o_done   = 1'b1;
                        o_val    = acc_shift;
                        acc_next = 32'd0;
                    end
                    if (sec_reg == SEC_QUESTION && pos_reg >= 4'd3) begin
                        rec_end = 1'b1;
                    end else if (sec_reg != SEC_QUESTION && pos_reg >= 4'd9) begin
                        rdata_next = acc_shift[15:0];
                        if (acc_shift[15:0] == 16'd0) begin
                            rec_end = 1'b1;
                        end else begin
                            phase_next = PH_RDATA;
                        end
                    end else begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                PH_RDATA: begin
                    o_code     = FLD_RDATA;
                    o_done     = 1'b1;
                    o_val      = {24'd0, s_tdata};
                    rdata_next = rdata_dec;
                    if (rdata_dec == 16'd0) begin
                        rec_end = 1'b1;
                    end
                end
                default: begin
                    o_code = 4'd0;
                end
            endcase
            if (rec_end) begin
                recnum_next = recnum_reg + 16'd1;
                left_next   = left_dec;
                phase_next  = PH_LABEL_LEN;
                pos_next    = 4'd0;
                acc_next    = 32'd0;
                if (left_dec == 16'd0) begin
                    ent         = enter_next(sec_reg, counts_reg);
                    o_mdone     = ent.done;
                    sec_next    = ent.sec;
                    left_next   = ent.count;
                    recnum_next = 16'd0;
                end
            end
        end else begin
            o_sec    = SEC_BEYOND;
            o_code   = FLD_EXTRA;
            o_status = ST_EXTRA;
            o_idx    = 16'd0;
        end

        if (s_tlast) begin
            if (o_sec < SEC_BEYOND && !o_mdone) begin
                o_status = ST_TRUNCATED;
            end
            sec_next    = SEC_HEADER;
            phase_next  = PH_LABEL_LEN;
            pos_next    = 4'd0;
            label_next  = 8'd0;
            acc_next    = 32'd0;
            left_next   = 16'd0;
            recnum_next = 16'd0;
            counts_next = '0;
            rdata_next  = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg      <= SEC_HEADER;
            phase_reg    <= PH_LABEL_LEN;
            pos_reg      <= 4'd0;
            label_reg    <= 8'd0;
            acc_reg      <= 32'd0;
            left_reg     <= 16'd0;
            recnum_reg   <= 16'd0;
            counts_reg   <= '0;
            rdata_reg    <= 16'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                sec_reg    <= sec_next;
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                label_reg  <= label_next;
                acc_reg    <= acc_next;
                left_reg   <= left_next;
                recnum_reg <= recnum_next;
                counts_reg <= counts_next;
                rdata_reg  <= rdata_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {5'd0, o_mdone, o_status, o_idx, o_done, o_val,
                            s_tdata, o_code, o_sec};
        end
    end

endmodule

### rtl/dnsmp_checker.sv
// ----------------------------------------------------------------------------
// DNS message parser port checker
// Watches the result channel for stalls and consistent tagging.
// ----------------------------------------------------------------------------
module dnsmp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dnsmp_pkg::M_TDATA_W-1:0] m_tdata
);
    import dnsmp_pkg::*;

    logic [2:0]  c_sec;
    logic [3:0]  c_code;
    logic        c_done;
    logic [15:0] c_idx;
    logic [1:0]  c_status;
    logic        c_mdone;

    assign c_sec    = m_tdata[2:0];
    assign c_code   = m_tdata[6:3];
    assign c_done   = m_tdata[47];
    assign c_idx    = m_tdata[63:48];
    assign c_status = m_tdata[65:64];
    assign c_mdone  = m_tdata[66];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && c_sec == SEC_BEYOND |->
            c_code == FLD_EXTRA && c_status == ST_EXTRA && !c_done && c_idx == 16'd0)
        else $error("bad tagging of extra byte");

    a_mdone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && c_mdone |-> c_done && c_status == ST_OK && c_sec != SEC_BEYOND)
        else $error("message end without completed field");

    a_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && c_sec == SEC_HEADER |-> c_idx == 16'd0 && c_code <= FLD_COUNT_LAST)
        else $error("bad header tagging");

endmodule

bind dns_message_stream_parser dnsmp_checker u_dnsmp_checker (.*);
